@@ design/ghbp_pkg.sv @@
// Shared types and constants of the global-history branch predictor.
// Used by the controller, the datapath, the top level and the checker.
package ghbp_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int COUNTER_BITS_DEF  = 2;
    localparam int THREADS_DEF       = 4;

    localparam int HIST_FIELD_W   = 10;
    localparam int THREAD_FIELD_W = 2;

    typedef enum logic [2:0] {
        KIND_LOOKUP = 3'd0,
        KIND_UNCOND = 3'd1,
        KIND_BTB_MISS = 3'd2,
        KIND_UPDATE = 3'd3,
        KIND_SQUASH = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [THREAD_FIELD_W-1:0] thread;
        logic [HIST_FIELD_W-1:0]   saved_history;
        logic                      outcome_taken;
        logic                      was_squashed;
    } in_item_t;

    typedef struct packed {
        logic                    pred_taken;
        logic [HIST_FIELD_W-1:0] history_snapshot;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

@@ design/ghbp_ctrl.sv @@
// Controller state machine of the branch predictor: clearing pass, accept, execute.
// Depends on ghbp_pkg; drives the datapath through cmd_t and reads status_t.
module ghbp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ghbp_pkg::status_t status,
    output ghbp_pkg::cmd_t    cmd
);

    ghbp_pkg::state_t state_reg;
    ghbp_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ghbp_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // the output slot is free when empty or its beat leaves this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ghbp_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ghbp_pkg::ST_IDLE;
                end
            end
            ghbp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ghbp_pkg::ST_EXEC;
                end
            end
            ghbp_pkg::ST_EXEC:
            begin
                // hold the item until the result has somewhere to go
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ghbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ghbp_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/ghbp_dpath.sv @@
// Datapath of the branch predictor: thread histories, counter memory, output register.
// Depends on ghbp_pkg; steered by the controller through cmd_t.
module ghbp_dpath
#(
    parameter int TABLE_ENTRIES = ghbp_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNTER_BITS  = ghbp_pkg::COUNTER_BITS_DEF,
    parameter int THREADS       = ghbp_pkg::THREADS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ghbp_pkg::cmd_t      cmd,
    output ghbp_pkg::status_t   status,
    input  ghbp_pkg::in_item_t  in_data,
    output ghbp_pkg::out_item_t out_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int HF    = ghbp_pkg::HIST_FIELD_W;
    localparam int TF    = ghbp_pkg::THREAD_FIELD_W;

    logic [COUNTER_BITS-1:0] ctr_mem [TABLE_ENTRIES];
    logic [COUNTER_BITS-1:0] rd_reg;

    logic [IDX_W-1:0]        hist_reg [THREADS];
    logic [IDX_W-1:0]        clr_idx_reg;
    ghbp_pkg::in_item_t      item_reg;
    ghbp_pkg::out_item_t     out_reg;

    // accept-side decode
    logic [IDX_W+HF-1:0]     in_saved_ext;
    logic [IDX_W-1:0]        in_saved_idx;
    logic [TID_W+TF-1:0]     in_tid_ext;
    logic [TID_W-1:0]        in_tid;
    logic                    in_tid_ok;
    logic [IDX_W-1:0]        in_hist;
    logic [IDX_W-1:0]        rd_addr;

    // execute-side decode
    logic [IDX_W+HF-1:0]     saved_ext;
    logic [IDX_W-1:0]        saved_idx;
    logic [TID_W+TF-1:0]     tid_ext;
    logic [TID_W-1:0]        tid;
    logic                    tid_ok;
    logic [IDX_W-1:0]        hist_cur;
    logic [IDX_W-1:0]        hist_new;
    logic [HF+IDX_W-1:0]     snap_ext;
    logic                    pred;
    logic                    ctr_we;
    logic [COUNTER_BITS-1:0] ctr_new;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [COUNTER_BITS-1:0] mem_wdata;

    assign in_saved_ext = {{IDX_W{1'b0}}, in_data.saved_history};
    assign in_saved_idx = in_saved_ext[IDX_W-1:0];
    assign in_tid_ext   = {{TID_W{1'b0}}, in_data.thread};
    assign in_tid       = in_tid_ext[TID_W-1:0];
    assign in_tid_ok    = int'(in_data.thread) < THREADS;
    assign in_hist      = in_tid_ok ? hist_reg[in_tid] : '0;
    assign rd_addr      = (in_data.kind == ghbp_pkg::KIND_UPDATE) ? in_saved_idx : in_hist;

    assign saved_ext = {{IDX_W{1'b0}}, item_reg.saved_history};
    assign saved_idx = saved_ext[IDX_W-1:0];
    assign tid_ext   = {{TID_W{1'b0}}, item_reg.thread};
    assign tid       = tid_ext[TID_W-1:0];
    assign tid_ok    = int'(item_reg.thread) < THREADS;
    assign hist_cur  = tid_ok ? hist_reg[tid] : '0;
    assign snap_ext  = {{HF{1'b0}}, hist_cur};

    always_comb
    begin
        pred     = 1'b0;
        hist_new = hist_cur;
        ctr_we   = 1'b0;
        ctr_new  = rd_reg;
        unique case (item_reg.kind)
            ghbp_pkg::KIND_LOOKUP:
            begin
                pred     = rd_reg[COUNTER_BITS-1];
                hist_new = (hist_cur << 1) | IDX_W'(rd_reg[COUNTER_BITS-1]);
            end
            ghbp_pkg::KIND_UNCOND:
            begin
                pred     = 1'b1;
                hist_new = (hist_cur << 1) | IDX_W'(1'b1);
            end
            ghbp_pkg::KIND_BTB_MISS:
            begin
                hist_new = hist_cur & ~IDX_W'(1'b1);
            end
            ghbp_pkg::KIND_UPDATE:
            begin
                ctr_we = tid_ok;
                // saturate at both ends
                if (item_reg.outcome_taken && (rd_reg != '1))
                begin
                    ctr_new = rd_reg + COUNTER_BITS'(1);
                end
                else if (!item_reg.outcome_taken && (rd_reg != '0))
                begin
                    ctr_new = rd_reg - COUNTER_BITS'(1);
                end
                if (item_reg.was_squashed)
                begin
                    hist_new = (saved_idx << 1) | IDX_W'(item_reg.outcome_taken);
                end
            end
            ghbp_pkg::KIND_SQUASH:
            begin
                hist_new = saved_idx;
            end
            default:
            begin
                hist_new = hist_cur;
            end
        endcase
    end

    assign mem_we    = cmd.clear_step || (cmd.exec && ctr_we);
    assign mem_waddr = cmd.clear_step ? clr_idx_reg : saved_idx;
    assign mem_wdata = cmd.clear_step ? '0 : ctr_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ctr_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            rd_reg <= ctr_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            for (int i = 0; i < THREADS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cmd.exec && tid_ok)
            begin
                hist_reg[tid] <= hist_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
        if (cmd.exec)
        begin
            // an ignored thread answers not taken
            out_reg.pred_taken       <= pred && tid_ok;
            out_reg.history_snapshot <= snap_ext[HF-1:0];
        end
    end

    assign status.clear_last = (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign out_data          = out_reg;

endmodule

@@ design/global_history_branch_predictor_unit.sv @@
// Global-history branch predictor, top level.
// Timing: an accepted item and its counter read are registered, then the execute state
// does the read-modify-write and registers the result beat, which holds while out_stall
// is high. One item is in flight at a time; execute waits until the output slot is free.
// Reset: histories clear at once; a clearing pass over all TABLE_ENTRIES entries zeroes
// the counter memory, during which in_stall stays high.
module global_history_branch_predictor_unit
#(
    parameter int TABLE_ENTRIES = ghbp_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNTER_BITS  = ghbp_pkg::COUNTER_BITS_DEF,
    parameter int THREADS       = ghbp_pkg::THREADS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ghbp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ghbp_pkg::out_item_t out_data
);

    ghbp_pkg::cmd_t    cmd;
    ghbp_pkg::status_t status;

    ghbp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ghbp_dpath
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNTER_BITS  (COUNTER_BITS),
        .THREADS       (THREADS)
    )
    u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

@@ design/ghbp_checker.sv @@
// Port-level checker for the branch predictor, bound to the top level.
// Depends on ghbp_pkg for the beat types.
module ghbp_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input ghbp_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input ghbp_pkg::out_item_t out_data
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // one item in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted while one is in flight");

    // a fresh result follows an earlier accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result beat without a matching accepted item");

endmodule

bind global_history_branch_predictor_unit ghbp_checker u_ghbp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ tb/sv/ghbp_checker.sv @@
// Scoreboard for the global-history branch predictor: watches both channels,
// keeps its own histories and counter table, and compares every result beat.
// Depends on ghbp_pkg for the beat types and the kind codes.
`timescale 1ns / 1ps

module ghbp_scoreboard
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  ghbp_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  ghbp_pkg::out_item_t out_data,
    output int                  fail_count,
    output int                  pending,
    output int                  checked
);

    localparam int CTR_W   = ghbp_pkg::COUNTER_BITS_DEF;
    localparam int HIST_W  = ghbp_pkg::HIST_FIELD_W;
    localparam int THREADS = ghbp_pkg::THREADS_DEF;
    localparam int ENTRIES = ghbp_pkg::TABLE_ENTRIES_DEF;

    logic [HIST_W-1:0]   history_regs [THREADS];
    logic [CTR_W-1:0]    counter_mem [ENTRIES];
    ghbp_pkg::out_item_t expected_results [$];

    // Apply one beat to the local state and return the result it should produce.
    function automatic ghbp_pkg::out_item_t predict_branch(input ghbp_pkg::in_item_t it);
        ghbp_pkg::out_item_t res;
        logic [HIST_W-1:0]   hist;
        logic [CTR_W-1:0]    ctr;
        hist = history_regs[it.thread];
        res.pred_taken = 1'b0;
        res.history_snapshot = hist;
        case (it.kind)
            ghbp_pkg::KIND_LOOKUP:
            begin
                // taken when the counter sits in the upper half
                res.pred_taken = counter_mem[hist][CTR_W-1];
                history_regs[it.thread] = {hist[HIST_W-2:0], res.pred_taken};
            end
            ghbp_pkg::KIND_UNCOND:
            begin
                res.pred_taken = 1'b1;
                history_regs[it.thread] = {hist[HIST_W-2:0], 1'b1};
            end
            ghbp_pkg::KIND_BTB_MISS:
            begin
                history_regs[it.thread] = {hist[HIST_W-1:1], 1'b0};
            end
            ghbp_pkg::KIND_UPDATE:
            begin
                ctr = counter_mem[it.saved_history];
                if (it.outcome_taken && ctr != {CTR_W{1'b1}})
                    ctr = ctr + CTR_W'(1);
                else if (!it.outcome_taken && ctr != '0)
                    ctr = ctr - CTR_W'(1);
                counter_mem[it.saved_history] = ctr;
                if (it.was_squashed)
                    history_regs[it.thread] =
                        {it.saved_history[HIST_W-2:0], it.outcome_taken};
            end
            ghbp_pkg::KIND_SQUASH:
            begin
                history_regs[it.thread] = it.saved_history;
            end
            default:
            begin
                // unused kinds leave the state alone
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ghbp_pkg::out_item_t exp_res;
        if (!rst_n)
        begin
            for (int t = 0; t < THREADS; t++)
                history_regs[t] = '0;
            for (int e = 0; e < ENTRIES; e++)
                counter_mem[e] = '0;
            expected_results.delete();
            fail_count = 0;
            checked = 0;
        end
        else
        begin
            // Compare first: a beat accepted at this edge cannot be answered yet.
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with nothing expected: pred %b hist %0d",
                                 $realtime, out_data.pred_taken,
                                 out_data.history_snapshot);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    checked++;
                    if (out_data.pred_taken !== exp_res.pred_taken ||
                        out_data.history_snapshot !== exp_res.history_snapshot)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch: pred exp %b got %b, hist exp %0d got %0d",
                                     $realtime, exp_res.pred_taken, out_data.pred_taken,
                                     exp_res.history_snapshot,
                                     out_data.history_snapshot);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_branch(in_data));
        end
        pending = expected_results.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// Top of the branch predictor testbench: clock, reset, directed and random beats,
// receiver back-pressure in several idling phases, and the verdict.
// Depends on ghbp_pkg, global_history_branch_predictor_unit and ghbp_scoreboard.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int THREAD_W    = ghbp_pkg::THREAD_FIELD_W;
    localparam int HIST_W      = ghbp_pkg::HIST_FIELD_W;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    ghbp_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    ghbp_pkg::out_item_t out_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;

    global_history_branch_predictor_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    ghbp_scoreboard checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    function automatic ghbp_pkg::in_item_t make_item(input logic [2:0] kind,
                                                     input int thread,
                                                     input int saved, input bit taken,
                                                     input bit squashed);
        ghbp_pkg::in_item_t it;
        it.kind = ghbp_pkg::kind_t'(kind);
        it.thread = THREAD_W'(thread);
        it.saved_history = HIST_W'(saved);
        it.outcome_taken = taken;
        it.was_squashed = squashed;
        return it;
    endfunction

    // Mostly realistic traffic: lookups and training at a few hot histories,
    // with full-range snapshots mixed in.
    function automatic ghbp_pkg::in_item_t random_branch_item();
        ghbp_pkg::in_item_t it;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 35)
            it.kind = ghbp_pkg::KIND_LOOKUP;
        else if (pick < 45)
            it.kind = ghbp_pkg::KIND_UNCOND;
        else if (pick < 55)
            it.kind = ghbp_pkg::KIND_BTB_MISS;
        else if (pick < 80)
            it.kind = ghbp_pkg::KIND_UPDATE;
        else if (pick < 94)
            it.kind = ghbp_pkg::KIND_SQUASH;
        else
            it.kind = ghbp_pkg::kind_t'(3'($urandom_range(7, 5)));
        it.thread = THREAD_W'($urandom_range(3));
        if ($urandom_range(1))
            it.saved_history = {($urandom_range(1) ? 7'h7f : 7'h00),
                                3'($urandom_range(7))};
        else
            it.saved_history = HIST_W'($urandom_range(1023));
        it.outcome_taken = 1'($urandom_range(1));
        it.was_squashed = ($urandom_range(99) < 30);
        return it;
    endfunction

    // Drive one beat and hold it until accepted, idling first at random.
    task automatic send_beat(input ghbp_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and hold until every expected result has arrived.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_phase(input int beats, input int idle_pct, input int stall_pct);
        @(posedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (beats)
            send_beat(random_branch_item());
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed: every kind, counter saturation at both ends, history extremes.
        send_beat(make_item(ghbp_pkg::KIND_LOOKUP, 0, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_UNCOND, 1, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_LOOKUP, 1, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_SQUASH, 2, 1023, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_LOOKUP, 2, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_BTB_MISS, 2, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_UNCOND, 2, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_BTB_MISS, 2, 1023, 1, 1));
        repeat (4)
            send_beat(make_item(ghbp_pkg::KIND_UPDATE, 0, 0, 1, 0));
        send_beat(make_item(ghbp_pkg::KIND_LOOKUP, 0, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_UPDATE, 3, 1023, 0, 1));
        send_beat(make_item(ghbp_pkg::KIND_UPDATE, 3, 1023, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_UPDATE, 3, 1023, 1, 1));
        send_beat(make_item(ghbp_pkg::KIND_LOOKUP, 3, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_SQUASH, 0, 0, 0, 0));
        send_beat(make_item(3'd5, 0, 1023, 1, 1));
        send_beat(make_item(3'd6, 1, 512, 0, 1));
        send_beat(make_item(3'd7, 3, 341, 1, 0));
        // walk the saturated counter back down across the half point
        send_beat(make_item(ghbp_pkg::KIND_UPDATE, 0, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_UPDATE, 0, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_SQUASH, 0, 0, 0, 0));
        send_beat(make_item(ghbp_pkg::KIND_LOOKUP, 0, 0, 0, 0));
        drain_results();

        random_phase(400, 0, 0);
        random_phase(400, 64, 0);
        random_phase(400, 0, 64);
        random_phase(300, 22, 22);

        $display("Sent %0d beats (directed kinds, saturation, unused kinds, random traffic)",
                 items_sent);
        $display("Checked %0d results across four idling phases, %0d failures",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
